@@ rtl/ssf_pkg.sv @@
`timescale 1ns / 1ps
// ssf_pkg: shared types, constants and helper functions for the six-digit
// segment formatter. No dependencies; imported by every module in rtl/.
package ssf_pkg;

   localparam int VALUE_WIDTH     = 20;
   localparam int DIGITS          = 6;
   localparam int BCD_WIDTH       = 4 * DIGITS;
   localparam int PIPE_STAGES     = 4;
   localparam int STEPS_PER_STAGE = VALUE_WIDTH / PIPE_STAGES;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISPLAY_MODE  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROTATE_AMOUNT = 4'd1;

   localparam logic [1:0] MODE_WAIT   = 2'd0;
   localparam logic [1:0] MODE_NUMBER = 2'd1;
   localparam logic [1:0] MODE_SPLIT  = 2'd2;

   localparam logic [7:0]  DASH_CODE    = 8'h02;
   localparam logic [7:0]  GRID_FIRST   = 8'h20;
   localparam logic [7:0]  GRID_LAST    = 8'h01;
   localparam logic [7:0]  GRID_CLOSE   = 8'hDF;
   localparam logic [2:0]  LAST_STROBE  = 3'd6;
   localparam logic [3:0]  FRAME_BLANK  = 4'd15;
   localparam logic [VALUE_WIDTH-1:0] BIG_LIMIT = 20'd1000000;

   typedef logic [DIGITS-1:0][7:0] ssf_words_type;

   typedef struct packed {
      logic [BCD_WIDTH-1:0]   bcd;
      logic [VALUE_WIDTH-1:0] bin;
      logic                   big;
      logic [3:0]             frame;
   } ssf_conv_type;

   typedef struct packed {
      logic [BCD_WIDTH-1:0] bcd;
      logic                 big;
      logic [3:0]           frame;
   } ssf_digits_type;

   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      case (digit)
         4'd0: code = 8'hfc;
         4'd1: code = 8'h60;
         4'd2: code = 8'hda;
         4'd3: code = 8'hf2;
         4'd4: code = 8'h66;
         4'd5: code = 8'hb6;
         4'd6: code = 8'hbe;
         4'd7: code = 8'he4;
         4'd8: code = 8'hfe;
         4'd9: code = 8'hf6;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   function automatic ssf_words_type wait_frame(input logic [3:0] f);
      ssf_words_type d;
      d = '0;
      case (f) inside
         4'd0: begin
            d[0] = 8'hf0; d[1] = 8'h90; d[2] = 8'h90;
            d[3] = 8'h90; d[4] = 8'h90; d[5] = 8'h9c;
         end
         [4'd1:4'd6]:  d[3'(f - 4'd1)] = 8'h80;
         4'd7:         d[5] = 8'h0c;
         [4'd8:4'd13]: d[3'(4'd13 - f)] = 8'h10;
         4'd14:        d[0] = 8'h60;
         default:      d = '0;
      endcase
      return d;
   endfunction

   // one shift-and-add-3 step over the joined decimal and binary words
   function automatic logic [BCD_WIDTH+VALUE_WIDTH-1:0] dabble_step(
      input logic [BCD_WIDTH+VALUE_WIDTH-1:0] s);
      logic [BCD_WIDTH+VALUE_WIDTH-1:0] t;
      t = s;
      for (int n = 0; n < DIGITS; n++) begin
         if (t[VALUE_WIDTH+4*n +: 4] >= 4'd5) begin
            t[VALUE_WIDTH+4*n +: 4] = t[VALUE_WIDTH+4*n +: 4] + 4'd3;
         end
      end
      return t << 1;
   endfunction

endpackage

@@ rtl/six_digit_segment_formatter.sv @@
`timescale 1ns / 1ps
// six_digit_segment_formatter: top level, configuration registers and the
// link of conversion pipe, formatter and scan output. Depends on ssf_pkg.
//
// Usage:
//   req_*  : one 20-bit value per transaction (valid / stall).
//   rsp_*  : seven transactions per value: digit selects 0x20 down to 0x01
//            with their segment bytes, then 0xDF with segments 0 and last.
//   csr_*  : register writes, index 0 display mode, index 1 rotate amount;
//            csr_ready is always high, other indexes are dropped. Write only
//            while no value is in flight.
// Pipeline: a value passes the input register and four conversion stages
//   before the scan output register shows its first strobe; the conversion pipe
//   has five register stages of which four run five decimal-adjust steps each.
// Scan: seven strobes of the scan output per value; a new value loads as the
//   last strobe is taken, and the pipe takes further values while a scan is running.
// Reset: clears both registers and empties the pipe and the scan output.
// Stall: rsp_stall holds the current strobe; the pipe fills behind it and
//   then raises req_stall.
module six_digit_segment_formatter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [ssf_pkg::VALUE_WIDTH-1:0]    req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_digit_select,
   output logic [7:0]                         rsp_segment_pattern,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ssf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [ssf_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import ssf_pkg::*;

   logic [1:0]     display_mode_ff, display_mode_in;
   logic [2:0]     rotate_amount_ff, rotate_amount_in;
   logic           conv_valid;
   logic           conv_ready;
   ssf_digits_type conv_digits;
   ssf_words_type  words;

   assign csr_ready = 1'b1;

   always_comb begin
      display_mode_in  = display_mode_ff;
      rotate_amount_in = rotate_amount_ff;
      if (csr_valid & csr_ready) begin
         unique case (csr_index)
            CSR_DISPLAY_MODE:  display_mode_in  = csr_data[1:0];
            CSR_ROTATE_AMOUNT: rotate_amount_in = csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff  <= MODE_WAIT;
         rotate_amount_ff <= '0;
      end else begin
         display_mode_ff  <= display_mode_in;
         rotate_amount_ff <= rotate_amount_in;
      end
   end

   ssf_bcd_pipe u_bcd_pipe (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .out_valid  (conv_valid),
      .out_ready  (conv_ready),
      .out_digits (conv_digits)
   );

   ssf_format u_format (
      .display_mode  (display_mode_ff),
      .rotate_amount (rotate_amount_ff),
      .digits        (conv_digits),
      .words         (words)
   );

   ssf_scan u_scan (
      .clock               (clock),
      .reset               (reset),
      .load_valid          (conv_valid),
      .load_ready          (conv_ready),
      .load_words          (words),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_digit_select    (rsp_digit_select),
      .rsp_segment_pattern (rsp_segment_pattern),
      .rsp_last            (rsp_last)
   );

endmodule

@@ rtl/ssf_bcd_pipe.sv @@
`timescale 1ns / 1ps
// ssf_bcd_pipe: input register and pipelined binary to decimal conversion,
// several shift-and-add-3 steps per stage. Depends on ssf_pkg.
module ssf_bcd_pipe (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ssf_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                           out_valid,
   input  logic                           out_ready,
   output ssf_pkg::ssf_digits_type        out_digits
);
   import ssf_pkg::*;

   logic [PIPE_STAGES:0] vld_ff, vld_in;
   logic [PIPE_STAGES:0] adv;
   logic                 load;
   ssf_conv_type         conv_ff [PIPE_STAGES+1];
   ssf_conv_type         conv_in [PIPE_STAGES+1];

   always_comb begin
      adv[PIPE_STAGES] = vld_ff[PIPE_STAGES] & out_ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         adv[k] = vld_ff[k] & (~vld_ff[k+1] | adv[k+1]);
      end
   end

   assign req_stall = vld_ff[0] & ~adv[0];
   assign load      = req_valid & ~req_stall;

   always_comb begin
      vld_in[0] = load | (vld_ff[0] & ~adv[0]);
      for (int k = 1; k <= PIPE_STAGES; k++) begin
         vld_in[k] = adv[k-1] | (vld_ff[k] & ~adv[k]);
      end
   end

   always_comb begin
      ssf_conv_type tmp;
      conv_in[0] = conv_ff[0];
      if (load) begin
         conv_in[0].bcd   = '0;
         conv_in[0].bin   = req_value;
         conv_in[0].big   = (req_value >= BIG_LIMIT);
         conv_in[0].frame = (req_value < VALUE_WIDTH'(FRAME_BLANK)) ?
                            req_value[3:0] : FRAME_BLANK;
      end
      for (int k = 1; k <= PIPE_STAGES; k++) begin
         tmp = conv_ff[k-1];
         for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            {tmp.bcd, tmp.bin} = dabble_step({tmp.bcd, tmp.bin});
         end
         conv_in[k] = adv[k-1] ? tmp : conv_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= PIPE_STAGES; k++) begin
         conv_ff[k] <= conv_in[k];
      end
   end

   assign out_valid        = vld_ff[PIPE_STAGES];
   assign out_digits.bcd   = conv_ff[PIPE_STAGES].bcd;
   assign out_digits.big   = conv_ff[PIPE_STAGES].big;
   assign out_digits.frame = conv_ff[PIPE_STAGES].frame;

endmodule

@@ rtl/ssf_format.sv @@
`timescale 1ns / 1ps
// ssf_format: builds the six segment words for the current display mode,
// with blanking, and rotation in the number and split modes. Depends on ssf_pkg.
module ssf_format (
   input  logic [1:0]              display_mode,
   input  logic [2:0]              rotate_amount,
   input  ssf_pkg::ssf_digits_type digits,
   output ssf_pkg::ssf_words_type  words
);
   import ssf_pkg::*;

   ssf_words_type d;
   logic          rotate_en;
   logic [2:0]    r6;
   logic [3:0]    sum;
   logic [2:0]    idx;

   always_comb begin
      d         = '0;
      rotate_en = 1'b0;
      unique case (display_mode)
         MODE_WAIT: begin
            d = wait_frame(digits.frame);
         end
         MODE_NUMBER: begin
            rotate_en = 1'b1;
            for (int j = 0; j < DIGITS; j++) begin
               d[j] = seg_code(digits.bcd[4*j +: 4]);
               if (j > 0 && !digits.big && (digits.bcd >> (4*j)) == '0) begin
                  d[j] = 8'h00;
               end
            end
         end
         MODE_SPLIT: begin
            rotate_en = 1'b1;
            d[5] = 8'h00;
            d[4] = seg_code(digits.bcd[15:12]);
            d[3] = seg_code(digits.bcd[11:8]);
            d[2] = DASH_CODE;
            d[1] = seg_code(digits.bcd[7:4]);
            d[0] = seg_code(digits.bcd[3:0]);
         end
         default: begin
            d = wait_frame(4'd0);
         end
      endcase
   end

   assign r6 = (rotate_amount >= 3'd6) ? rotate_amount - 3'd6 : rotate_amount;

   always_comb begin
      sum = '0;
      idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         sum = 4'(i) + {1'b0, r6};
         idx = (sum >= 4'd6) ? 3'(sum - 4'd6) : sum[2:0];
         words[i] = rotate_en ? d[idx] : d[i];
      end
   end

endmodule

@@ rtl/ssf_scan.sv @@
`timescale 1ns / 1ps
// ssf_scan: output register that plays one word set out as seven strobes,
// six digit selects and the closing strobe. Depends on ssf_pkg.
module ssf_scan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load_valid,
   output logic                  load_ready,
   input  ssf_pkg::ssf_words_type load_words,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_digit_select,
   output logic [7:0]            rsp_segment_pattern,
   output logic                  rsp_last
);
   import ssf_pkg::*;

   logic          busy_ff, busy_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [7:0]    grid_ff, grid_in;
   ssf_words_type words_ff, words_in;
   logic          take;
   logic          final_take;
   logic          load;

   assign take       = busy_ff & ~rsp_stall;
   assign final_take = take & (cnt_ff == LAST_STROBE);
   assign load_ready = ~busy_ff | final_take;
   assign load       = load_valid & load_ready;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      grid_in  = grid_ff;
      words_in = words_ff;
      if (load) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         grid_in  = GRID_FIRST;
         words_in = load_words;
      end else if (final_take) begin
         busy_in = 1'b0;
      end else if (take) begin
         cnt_in   = cnt_ff + 3'd1;
         grid_in  = (grid_ff == GRID_LAST) ? GRID_CLOSE : grid_ff >> 1;
         words_in = {8'h00, words_ff[DIGITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      grid_ff  <= grid_in;
      words_ff <= words_in;
   end

   assign rsp_valid           = busy_ff;
   assign rsp_digit_select    = grid_ff;
   assign rsp_segment_pattern = words_ff[0];
   assign rsp_last            = (cnt_ff == LAST_STROBE);

endmodule
